@@ rtl/ffrm_pkg.sv @@
// ----------------------------------------------------------------------------
// ffrm_pkg: shared types and constants of the first-fit resource map
// Entry layout, sizes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ffrm_pkg;
	localparam int MAP_ENTRIES = 64;
	localparam int UNIT_BITS   = 16;
	localparam int IDX_W       = $clog2(MAP_ENTRIES);
	localparam int CNT_W       = $clog2(MAP_ENTRIES + 1);

	typedef struct packed {
		logic [UNIT_BITS-1:0] start;
		logic [UNIT_BITS-1:0] length;
	} ext_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;
endpackage
`default_nettype wire

@@ rtl/ffrm_ram.sv @@
// ----------------------------------------------------------------------------
// ffrm_ram: simple dual-port extent memory
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module ffrm_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/first_fit_resource_map.sv @@
// Work: the scan reads and checks the extents in order; an allocate that uses up its extent,
// or a free that merges both sides or inserts, then shifts the later extents one by one
// before the result beat is registered.
// Flow: one item in work at a time; the next beat is taken at the earliest together
// with the result beat.
// Reset empties the list at once (count to zero); no clearing pass is needed.
// ----------------------------------------------------------------------------
// first_fit_resource_map: first-fit allocator over a sorted free-extent list
// Allocates and frees extents, merging neighbours and keeping the list sorted.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_resource_map (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         action,
	input  wire  [15:0] base_address,
	input  wire  [15:0] request_size,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [15:0] granted_address,
	output logic [1:0]  status,
	output logic [6:0]  extent_count
);
	localparam int IW = ffrm_pkg::IDX_W;
	localparam int CW = ffrm_pkg::CNT_W;
	localparam int UB = ffrm_pkg::UNIT_BITS;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SRD    = 9'b000000010,
		S_SCHK   = 9'b000000100,
		S_FDEC   = 9'b000001000,
		S_SHD_RD = 9'b000010000,
		S_SHD_WR = 9'b000100000,
		S_SHU_RD = 9'b001000000,
		S_SHU_WR = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t              st_q, st_d;
	logic [CW-1:0]       idx_q, idx_d, cnt_q, cnt_d, held_q, held_d;
	ffrm_pkg::ext_t      prev_q, prev_d, cur_q, cur_d, rdata, wdata;
	ffrm_pkg::status_t   stat_q, stat_d;
	logic [UB-1:0]       gnt_q, gnt_d;
	logic                act_q;
	logic [UB-1:0]       addr_q, size_q;
	logic                we;
	logic [IW-1:0]       waddr, raddr;
	logic                in_acc;

	logic [UB:0]   lo_end, lo_sum, up_end, up_sum, a_len;
	logic [UB+1:0] both_sum;
	logic          low_ok, up_ok, both_ok;

	ffrm_ram #(.DEPTH(ffrm_pkg::MAP_ENTRIES), .WIDTH(2 * UB)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign in_ready = (st_q == S_IDLE) && (!out_valid || out_ready);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		lo_end   = {1'b0, prev_q.start} + {1'b0, prev_q.length};
		lo_sum   = {1'b0, prev_q.length} + {1'b0, size_q};
		up_end   = {1'b0, addr_q} + {1'b0, size_q};
		up_sum   = {1'b0, size_q} + {1'b0, cur_q.length};
		both_sum = {1'b0, lo_sum} + {2'b00, cur_q.length};
		a_len    = {1'b0, rdata.length} - {1'b0, size_q};
		low_ok   = (idx_q != '0) && (lo_end == {1'b0, addr_q}) && !lo_sum[UB];
		up_ok    = (idx_q != held_q) && (up_end == {1'b0, cur_q.start});
		both_ok  = (both_sum[UB+1:UB] == 2'b00);
	end

	always_comb begin
		st_d   = st_q;
		idx_d  = idx_q;
		cnt_d  = cnt_q;
		held_d = held_q;
		prev_d = prev_q;
		cur_d  = cur_q;
		stat_d = stat_q;
		gnt_d  = gnt_q;
		we     = 1'b0;
		waddr  = idx_q[IW-1:0];
		wdata  = rdata;
		raddr  = idx_q[IW-1:0];
		case (st_q)
			S_IDLE: begin
				if (in_acc) begin
					idx_d  = '0;
					stat_d = ffrm_pkg::ST_DONE;
					gnt_d  = '0;
					st_d   = (action && request_size == '0) ? S_FIN : S_SRD;
				end
			end
			S_SRD: begin
				if (idx_q == held_q) begin
					if (!act_q) begin
						stat_d = ffrm_pkg::ST_NOFIT;
						st_d   = S_FIN;
					end else begin
						st_d = S_FDEC;
					end
				end else begin
					st_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (!act_q) begin
					if (rdata.length >= size_q) begin
						gnt_d = rdata.start;
						if (a_len[UB-1:0] != '0) begin
							we          = 1'b1;
							wdata.start  = rdata.start + size_q;
							wdata.length = a_len[UB-1:0];
							st_d        = S_FIN;
						end else begin
							cnt_d = idx_q;
							st_d  = S_SHD_RD;
						end
					end else begin
						idx_d = idx_q + 1'b1;
						st_d  = S_SRD;
					end
				end else if (rdata.start <= addr_q) begin
					prev_d = rdata;
					idx_d  = idx_q + 1'b1;
					st_d   = S_SRD;
				end else begin
					cur_d = rdata;
					st_d  = S_FDEC;
				end
			end
			S_FDEC: begin
				waddr = IW'(idx_q - 1'b1);
				if (low_ok) begin
					we          = 1'b1;
					wdata.start = prev_q.start;
					if (up_ok && both_ok) begin
						wdata.length = both_sum[UB-1:0];
						cnt_d        = idx_q;
						st_d         = S_SHD_RD;
					end else begin
						wdata.length = lo_sum[UB-1:0];
						st_d         = S_FIN;
					end
				end else if (up_ok && !up_sum[UB]) begin
					we           = 1'b1;
					waddr        = idx_q[IW-1:0];
					wdata.start  = addr_q;
					wdata.length = up_sum[UB-1:0];
					st_d         = S_FIN;
				end else if (held_q == CW'(ffrm_pkg::MAP_ENTRIES)) begin
					stat_d = ffrm_pkg::ST_FULL;
					st_d   = S_FIN;
				end else begin
					cnt_d = held_q;
					st_d  = S_SHU_RD;
				end
			end
			S_SHD_RD: begin
				raddr = IW'(cnt_q + 1'b1);
				if (CW'(cnt_q + 1'b1) == held_q) begin
					held_d = held_q - 1'b1;
					st_d   = S_FIN;
				end else begin
					st_d = S_SHD_WR;
				end
			end
			S_SHD_WR: begin
				we    = 1'b1;
				waddr = cnt_q[IW-1:0];
				cnt_d = cnt_q + 1'b1;
				st_d  = S_SHD_RD;
			end
			S_SHU_RD: begin
				raddr = IW'(cnt_q - 1'b1);
				if (cnt_q == idx_q) begin
					we           = 1'b1;
					waddr        = idx_q[IW-1:0];
					wdata.start  = addr_q;
					wdata.length = size_q;
					held_d       = held_q + 1'b1;
					st_d         = S_FIN;
				end else begin
					st_d = S_SHU_WR;
				end
			end
			S_SHU_WR: begin
				we    = 1'b1;
				waddr = cnt_q[IW-1:0];
				cnt_d = cnt_q - 1'b1;
				st_d  = S_SHU_RD;
			end
			S_FIN: begin
				st_d = S_IDLE;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q   <= st_d;
			held_q <= held_d;
			if (st_q == S_FIN) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		cnt_q  <= cnt_d;
		prev_q <= prev_d;
		cur_q  <= cur_d;
		stat_q <= stat_d;
		gnt_q  <= gnt_d;
		if (in_acc) begin
			act_q  <= action;
			addr_q <= base_address;
			size_q <= request_size;
		end
		if (st_q == S_FIN) begin
			granted_address <= gnt_q;
			status          <= stat_q;
			extent_count    <= 7'(held_q);
		end
	end

	// The list never grows past its capacity.
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(ffrm_pkg::MAP_ENTRIES))
		else $error("extent count above capacity");

	// A dropped free is reported only against a full list.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN && stat_q == ffrm_pkg::ST_FULL) |->
		held_q == CW'(ffrm_pkg::MAP_ENTRIES))
		else $error("full status with room left");

	// Writes land within the held list, or one past it while inserting.
	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ({1'b0, waddr} < held_q || (st_q == S_SHU_WR) || (st_q == S_SHU_RD)))
		else $error("write beyond held extents");

	// A failed or dropped request never carries an address.
	a_gnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN && stat_q != ffrm_pkg::ST_DONE) |-> gnt_q == '0)
		else $error("address on failed request");
endmodule
`default_nettype wire

@@ bench/extent_map_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extent_map_checker: predicts and checks the first-fit extent map results
// Watches both channels, keeps its own sorted free list, and compares every
// result beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module extent_map_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire         action,
	input  wire  [15:0] base_address,
	input  wire  [15:0] request_size,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [15:0] granted_address,
	input  wire  [1:0]  status,
	input  wire  [6:0]  extent_count,
	output int          mismatches,
	output int          pending,
	output int          grants_seen,
	output int          fulls_seen,
	output int          nofits_seen,
	output int          peak_extents
);
	typedef struct packed {
		logic [15:0]       grant;
		ffrm_pkg::status_t st;
		logic [6:0]        held;
	} outcome_t;

	localparam logic [16:0] UNIT_MAX = 17'hFFFF;

	logic [15:0] free_start [ffrm_pkg::MAP_ENTRIES];
	logic [15:0] free_len   [ffrm_pkg::MAP_ENTRIES];
	int          free_held;
	outcome_t    awaited [$];

	initial begin
		mismatches   = 0;
		pending      = 0;
		grants_seen  = 0;
		fulls_seen   = 0;
		nofits_seen  = 0;
		peak_extents = 0;
		free_held    = 0;
	end

	function automatic void drop_extent(input int i);
		for (int k = i; k < free_held - 1; k++) begin
			free_start[k] = free_start[k + 1];
			free_len[k]   = free_len[k + 1];
		end
		free_held--;
	endfunction

	function automatic outcome_t map_step(input logic act, input logic [15:0] addr,
			input logic [15:0] size);
		outcome_t    r;
		int          i;
		logic        lo_ok, up_ok;
		logic [16:0] len;
		r = '{grant: 16'd0, st: ffrm_pkg::ST_DONE, held: 7'd0};
		if (act == 1'b0) begin
			r.st = ffrm_pkg::ST_NOFIT;
			for (i = 0; i < free_held; i++) begin
				if (free_len[i] >= size) begin
					r.grant = free_start[i];
					r.st = ffrm_pkg::ST_DONE;
					free_start[i] = free_start[i] + size;
					free_len[i] = free_len[i] - size;
					if (free_len[i] == 16'd0) drop_extent(i);
					break;
				end
			end
		end else if (size != 16'd0) begin
			i = 0;
			while (i < free_held && free_start[i] <= addr) i++;
			lo_ok = i > 0 && ({1'b0, free_start[i-1]} + free_len[i-1] == {1'b0, addr})
				&& ({1'b0, free_len[i-1]} + size <= UNIT_MAX);
			up_ok = i < free_held && ({1'b0, addr} + size == {1'b0, free_start[i]});
			if (lo_ok) begin
				len = {1'b0, free_len[i-1]} + size;
				if (up_ok && len + free_len[i] <= UNIT_MAX) begin
					len = len + free_len[i];
					drop_extent(i);
				end
				free_len[i-1] = len[15:0];
			end else if (up_ok && {1'b0, size} + free_len[i] <= UNIT_MAX) begin
				free_start[i] = addr;
				free_len[i] = size + free_len[i];
			end else if (free_held >= ffrm_pkg::MAP_ENTRIES) begin
				r.st = ffrm_pkg::ST_FULL;
			end else begin
				for (int k = free_held; k > i; k--) begin
					free_start[k] = free_start[k - 1];
					free_len[k]   = free_len[k - 1];
				end
				free_start[i] = addr;
				free_len[i] = size;
				free_held++;
			end
		end
		r.held = free_held[6:0];
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		outcome_t w;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				awaited.push_back(map_step(action, base_address, request_size));
				if (free_held > peak_extents) peak_extents = free_held;
			end
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					w = awaited.pop_front();
					if (granted_address != w.grant)
						report("granted_address", granted_address, w.grant);
					if (status != w.st) report("status", status, w.st);
					if (extent_count != w.held) report("extent_count", extent_count, w.held);
					if (w.st == ffrm_pkg::ST_FULL) fulls_seen++;
					if (w.st == ffrm_pkg::ST_NOFIT) nofits_seen++;
					if (w.st == ffrm_pkg::ST_DONE && w.grant != 0) grants_seen++;
				end
			end
			pending = awaited.size();
		end
	end
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the first-fit resource map
// Drives allocate and free beats under varying idle and stall patterns and
// leaves all checking to the extent map checker.
// ----------------------------------------------------------------------------
module testbench;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;
	localparam int   WATCHDOG  = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [15:0] base_address;
	logic [15:0] request_size;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] granted_address;
	logic [1:0]  status;
	logic [6:0]  extent_count;
	int          mismatches, pending, grants_seen, fulls_seen, nofits_seen, peak_extents;
	int          send_idle, stall_pct, quiet;
	int          beats_sent;
	logic        hold_off;

	first_fit_resource_map dut (.*);

	extent_map_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_ALLOC;
		base_address = '0;
		request_size = '0;
		out_ready    = 1'b0;
		send_idle    = 0;
		stall_pct    = 0;
		hold_off     = 1'b0;
		beats_sent   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Receiver: random stalls, or a long hold-off while the sender keeps offering.
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: cycles without any accepted beat.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Valid stays high after a beat when the next one follows at once.
	task automatic send(input logic act, input logic [15:0] addr, input logic [15:0] size);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		base_address <= addr;
		request_size <= size;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly small sizes, sometimes anything, to exercise fits and failures.
	function automatic logic [15:0] pick_size();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'($urandom);
			2: return 16'hFFFF - 16'($urandom_range(3));
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	task automatic random_phase(input int count, input int idle, input int stall);
		logic [15:0] a;
		send_idle = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: send(ACT_ALLOC, 16'($urandom), pick_size());
				4, 5, 6: begin
					// Scattered small frees in a narrow window make merges likely.
					a = 16'($urandom_range(0, 2000));
					send(ACT_FREE, a, 16'($urandom_range(1, 12)));
				end
				7: send(ACT_FREE, 16'($urandom), pick_size());
				8: send(ACT_FREE, 16'(3 * $urandom_range(0, 700)), 16'd2);
				default: send(ACT_FREE, 16'($urandom), 16'($urandom));
			endcase
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// Directed: empty list, boundaries, merges both sides, overflow guards.
		send(ACT_ALLOC, 16'h0000, 16'd0);
		send(ACT_ALLOC, 16'hFFFF, 16'd5);
		send(ACT_FREE,  16'h1234, 16'd0);
		send(ACT_FREE,  16'd100,  16'd10);
		send(ACT_FREE,  16'd120,  16'd10);
		send(ACT_FREE,  16'd110,  16'd10);
		send(ACT_FREE,  16'd0,    16'd50);
		send(ACT_ALLOC, 16'd0,    16'd0);
		send(ACT_ALLOC, 16'd0,    16'd50);
		send(ACT_ALLOC, 16'd0,    16'd31);
		send(ACT_ALLOC, 16'd0,    16'hFFFF);
		send(ACT_FREE,  16'hFFF0, 16'h0010);
		send(ACT_ALLOC, 16'd0,    16'h0010);
		send(ACT_FREE,  16'd1000, 16'hFFFF);
		send(ACT_FREE,  16'd999,  16'd1);
		send(ACT_FREE,  16'd0,    16'hFFFF);
		send(ACT_ALLOC, 16'd0,    16'hFFFF);
		send(ACT_FREE,  16'hFFFF, 16'hFFFF);
		send(ACT_ALLOC, 16'hAAAA, 16'h5555);
		send(ACT_FREE,  16'h5555, 16'hAAAA);
		wait_drain();
		// Fill the list with isolated extents, three more than its capacity, to hit the full case.
		for (int k = 0; k < ffrm_pkg::MAP_ENTRIES + 3; k++)
			send(ACT_FREE, 16'd40000 + 16'(k * 4), 16'd2);
		// Long receiver hold-off, timed in its own process, while frees keep arriving.
		hold_off <= 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		for (int k = 0; k < 6; k++) send(ACT_FREE, 16'd42 + 16'(k * 3), 16'd1);
		for (int k = 0; k < 40; k++) send(ACT_ALLOC, 16'd0, 16'd2);
		random_phase(320, 0, 0);
		random_phase(320, 77, 0);
		random_phase(320, 0, 77);
		random_phase(320, 8, 8);
		stall_pct = 0;
		wait_drain();
		repeat (4 * ffrm_pkg::MAP_ENTRIES + 20) @(posedge clk);
		$display("Sent %0d beats; %0d nonzero grants, %0d no-fit, %0d list-full results.",
			beats_sent, grants_seen, nofits_seen, fulls_seen);
		$display("Peak free list occupancy %0d extents.", peak_extents);
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
